### src/cwl_pkg.sv
// ----------------------------------------------------------------------------
// cwl_pkg
// Types and codes used by the compacting word list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cwl_pkg;

  // command codes
  localparam logic [3:0] CMD_WRITE     = 4'd0;
  localparam logic [3:0] CMD_APPEND    = 4'd1;
  localparam logic [3:0] CMD_READ      = 4'd2;
  localparam logic [3:0] CMD_DEL_INDEX = 4'd3;
  localparam logic [3:0] CMD_DEL_FIRST = 4'd4;
  localparam logic [3:0] CMD_DEL_ALL   = 4'd5;
  localparam logic [3:0] CMD_FIND      = 4'd6;
  localparam logic [3:0] CMD_COUNT     = 4'd7;
  localparam logic [3:0] CMD_CLEAR     = 4'd8;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_RANGE    = 2'd1;
  localparam logic [1:0] STATUS_NO_ENTRY = 2'd2;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [7:0]  position;
    logic [31:0] data_word;
  } cwl_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] answer;
    logic [8:0]  length;
    logic [1:0]  status;
  } cwl_out_t;

endpackage

`default_nettype wire

### src/cwl_store.sv
// ----------------------------------------------------------------------------
// cwl_store
// Word store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cwl_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/compacting_word_list_engine.sv
// ----------------------------------------------------------------------------
// compacting_word_list_engine
// Dense word list with indexed access, search, counting and compacting delete.
// ----------------------------------------------------------------------------
// The engine holds up to CAPACITY words of WORD_BITS bits and a fill count.
// One command is taken at a time and gives exactly one result transfer. All
// work goes through a single-port-write, single-port-read memory under a small
// sequencer, which touches one entry per cycle: a write past the end fills the
// gap with the default word; find, count, delete first and delete all walk the
// whole list; delete at index walks from the position to the end. A finished
// result sits in an output register, so the next command can be taken while
// it waits. The default word is written through its own port; the user must
// write it only while the engine is idle, as the block does not enforce this.
// A reset needs no clearing pass because entries at or past the fill count
// are never read back. Words wider than WORD_BITS are cut to WORD_BITS, and
// read words come back zero extended to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_word_list_engine #(
  parameter int CAPACITY  = 256,
  parameter int WORD_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire cwl_pkg::cwl_in_t  cmd_item,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output cwl_pkg::cwl_out_t    rsp_item,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [31:0]     cfg_data
);

  import cwl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [31:0] CAP32 = 32'(CAPACITY);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_FILL   = 6'b000100,
    ST_RDWAIT = 6'b001000,
    ST_SCAN   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  // latched command
  logic [3:0]           cmd_r;
  logic [7:0]           pos_r;
  logic [WORD_BITS-1:0] key, key_next;

  // list state and walk pointers
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] rp, rp_next;
  logic [CW-1:0] wp, wp_next;
  logic [CW-1:0] pidx, pidx_next;
  logic          pend, pend_next;

  // result being built
  logic        hit, hit_next;
  logic [31:0] answer, answer_next;
  logic [1:0]  status, status_next;

  logic [WORD_BITS-1:0] default_word;

  // memory port
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic [63:0] wide_in;
  logic [63:0] wide_cfg;
  logic [63:0] wide_rd;
  logic [63:0] wide_dflt;
  logic [31:0] pos32;
  logic [31:0] fill32;
  logic        match;
  logic        drop;
  logic        is_del;

  cwl_store #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign cmd_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // field width adaption: cut to or zero extend from WORD_BITS
  assign wide_in   = {32'd0, cmd_item.data_word};
  assign wide_cfg  = {32'd0, cfg_data};
  assign wide_rd   = 64'(mem_rdata);
  assign wide_dflt = 64'(default_word);

  assign pos32  = 32'(pos_r);
  assign fill32 = 32'(fill);

  // scan decision for the word coming back from the memory
  assign match  = (mem_rdata == key);
  assign is_del = (cmd_r == CMD_DEL_INDEX) || (cmd_r == CMD_DEL_FIRST) ||
                  (cmd_r == CMD_DEL_ALL);

  always_comb begin
    case (cmd_r)
      CMD_DEL_INDEX: drop = (32'(pidx) == pos32);
      CMD_DEL_FIRST: drop = match && !hit;
      CMD_DEL_ALL:   drop = match;
      default:       drop = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_next  = state;
    key_next    = key;
    fill_next   = fill;
    rp_next     = rp;
    wp_next     = wp;
    pidx_next   = pidx;
    pend_next   = pend;
    hit_next    = hit;
    answer_next = answer;
    status_next = status;
    mem_we      = 1'b0;
    mem_waddr   = wp[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = rp[AW-1:0];

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          key_next    = wide_in[WORD_BITS-1:0];
          hit_next    = 1'b0;
          answer_next = 32'd0;
          status_next = STATUS_OK;
          pend_next   = 1'b0;
          state_next  = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_next = ST_DONE;
        case (cmd_r)
          CMD_WRITE: begin
            if (pos32 >= CAP32) begin
              status_next = STATUS_RANGE;
            end else if (pos32 < fill32) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(pos_r);
              mem_wdata = key;
            end else begin
              // grow the list, filling any gap with the default word
              rp_next    = fill;
              state_next = ST_FILL;
            end
          end
          CMD_APPEND: begin
            if (fill32 >= CAP32) begin
              status_next = STATUS_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = fill[AW-1:0];
              mem_wdata = key;
              fill_next = fill + CW'(1);
            end
          end
          CMD_READ: begin
            if (pos32 >= CAP32) begin
              status_next = STATUS_RANGE;
              answer_next = wide_dflt[31:0];
            end else if (pos32 < fill32) begin
              mem_re     = 1'b1;
              mem_raddr  = AW'(pos_r);
              state_next = ST_RDWAIT;
            end else begin
              answer_next = wide_dflt[31:0];
            end
          end
          CMD_DEL_INDEX: begin
            if (pos32 >= CAP32) begin
              status_next = STATUS_RANGE;
            end else if (pos32 >= fill32) begin
              status_next = STATUS_NO_ENTRY;
            end else begin
              // entries below the position stay where they are
              rp_next    = CW'(pos_r);
              wp_next    = CW'(pos_r);
              state_next = ST_SCAN;
            end
          end
          CMD_DEL_FIRST, CMD_DEL_ALL, CMD_FIND, CMD_COUNT: begin
            rp_next    = '0;
            wp_next    = '0;
            state_next = ST_SCAN;
          end
          CMD_CLEAR: begin
            fill_next = '0;
          end
          default: begin
          end
        endcase
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = rp[AW-1:0];
        if (32'(rp) == pos32) begin
          mem_wdata  = key;
          fill_next  = rp + CW'(1);
          state_next = ST_DONE;
        end else begin
          mem_wdata = default_word;
          rp_next   = rp + CW'(1);
        end
      end

      ST_RDWAIT: begin
        answer_next = wide_rd[31:0];
        state_next  = ST_DONE;
      end

      ST_SCAN: begin
        // issue the next read
        if (rp < fill) begin
          mem_re    = 1'b1;
          mem_raddr = rp[AW-1:0];
          rp_next   = rp + CW'(1);
          pidx_next = rp;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end

        // handle the word read last cycle
        if (pend) begin
          if (is_del && !drop) begin
            mem_we    = 1'b1;
            mem_waddr = wp[AW-1:0];
            mem_wdata = mem_rdata;
            wp_next   = wp + CW'(1);
          end
          case (cmd_r)
            CMD_COUNT: begin
              if (match) begin
                answer_next = answer + 32'd1;
              end
            end
            CMD_FIND, CMD_DEL_FIRST: begin
              if (match && !hit) begin
                hit_next    = 1'b1;
                answer_next = 32'(pidx);
              end
            end
            default: begin
            end
          endcase
        end

        // walk finished
        if (!pend && (rp >= fill)) begin
          if (is_del) begin
            fill_next = wp;
          end
          if (cmd_r == CMD_DEL_ALL) begin
            answer_next = 32'(fill - wp);
          end
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      pend  <= pend_next;
    end
  end

  // payload registers of the sequencer
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) begin
      cmd_r <= cmd_item.cmd;
      pos_r <= cmd_item.position;
    end
    key    <= key_next;
    rp     <= rp_next;
    wp     <= wp_next;
    pidx   <= pidx_next;
    hit    <= hit_next;
    answer <= answer_next;
    status <= status_next;
  end

  // default word register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_word <= '0;
    end else if (cfg_valid) begin
      default_word <= wide_cfg[WORD_BITS-1:0];
    end
  end

  // output register, loaded when the sequencer hands over a result
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!rsp_valid || rsp_ready)) begin
      rsp_item.found  <= hit;
      rsp_item.answer <= answer;
      rsp_item.length <= 9'(fill);
      rsp_item.status <= status;
    end
  end

endmodule

`default_nettype wire
